// ===== hw/rtl/hrd_pkg.sv =====
// Shared types and constants of the HID report event decoder.
`timescale 1ns / 1ps

package hrd_pkg;

    localparam int MAX_SLOTS          = 6;
    localparam int KEY_SLOTS_DEFAULT  = 6;
    localparam int QUEUE_DEPTH        = 2;
    localparam int EVENT_SLOTS        = 2 * MAX_SLOTS;

    localparam logic [1:0] DEV_KEYBOARD  = 2'd0;
    localparam logic [1:0] DEV_MOUSE     = 2'd1;

    localparam logic [1:0] LAYOUT_DPAD   = 2'd1;
    localparam logic [1:0] LAYOUT_STICKS = 2'd2;

    localparam logic [4:0] KEY_MIN_LEN   = 5'd8;
    localparam logic [4:0] MOUSE_MIN_LEN = 5'd5;
    localparam logic [4:0] WHEEL_MIN_LEN = 5'd6;
    localparam logic [4:0] PAD_MIN_LEN   = 5'd7;

    localparam logic [7:0] AXIS_LOW      = 8'h40;
    localparam logic [7:0] AXIS_HIGH     = 8'hC0;
    localparam logic [7:0] STICK_BIAS    = 8'h80;

    localparam logic [1:0] DIR_NEG       = 2'b11;
    localparam logic [1:0] DIR_ZERO      = 2'b00;
    localparam logic [1:0] DIR_POS       = 2'b01;

    typedef enum logic [1:0] {
        EV_KEY   = 2'd0,
        EV_MOUSE = 2'd1,
        EV_PAD   = 2'd2
    } ev_kind_t;

    // One decoded report waiting for the back end. Bits of mask below
    // MAX_SLOTS are releases, the rest presses; non-key jobs use bit 0.
    typedef struct packed {
        ev_kind_t                        kind;
        logic [7:0]                      mods;
        logic [EVENT_SLOTS-1:0]          mask;
        logic [EVENT_SLOTS-1:0][7:0]     codes;
        logic [7:0]                      mx;
        logic [7:0]                      my;
        logic [11:0]                     btn;
        logic [7:0]                      wheel;
        logic [1:0]                      ph;
        logic [1:0]                      pv;
        logic [31:0]                     stick;
    } hrd_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hrd_q_status_t;

endpackage

// ===== hw/rtl/hrd_front.sv =====
// Front end: accept a report, classify it, diff keys and build a job.
`timescale 1ns / 1ps

module hrd_front #(
    parameter int KEY_SLOTS = hrd_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            device_kind,
    input  logic [4:0]            report_length,
    input  logic [31:0]           report_bytes_low,
    input  logic [31:0]           report_bytes_high,
    input  logic [1:0]            layout,
    input  hrd_pkg::hrd_q_status_t q_status,
    output logic                  push,
    output hrd_pkg::hrd_job_t     job
);
    import hrd_pkg::*;

    logic [7:0] prev_keys_reg  [KEY_SLOTS];
    logic [7:0] prev_keys_next [KEY_SLOTS];
    logic [7:0] b [8];
    logic       accept;
    logic       is_key;
    logic       is_mouse;
    logic       is_pad;
    logic       found;
    logic [3:0] hat;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b[i]     = report_bytes_low[8*i +: 8];
            b[4 + i] = report_bytes_high[8*i +: 8];
        end
    end

    assign is_key   = (device_kind == DEV_KEYBOARD) && (report_length >= KEY_MIN_LEN);
    assign is_mouse = (device_kind == DEV_MOUSE) && (report_length >= MOUSE_MIN_LEN);
    assign is_pad   = !is_key && !is_mouse && (report_length >= PAD_MIN_LEN)
                      && ((layout == LAYOUT_DPAD) || (layout == LAYOUT_STICKS));
    assign hat      = b[5][3:0];

    always_comb
    begin
        job   = '0;
        found = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            prev_keys_next[i] = prev_keys_reg[i];
        end
        if (is_key)
        begin
            job.kind = EV_KEY;
            job.mods = b[0];
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                // release: an old code that no new slot carries
                found = 1'b0;
                for (int j = 0; j < KEY_SLOTS; j++)
                begin
                    if (b[2 + j] == prev_keys_reg[i])
                    begin
                        found = 1'b1;
                    end
                end
                job.codes[i] = prev_keys_reg[i];
                job.mask[i]  = (prev_keys_reg[i] != 8'd0) && !found;
                // press: a new code that no old slot carries
                found = 1'b0;
                for (int j = 0; j < KEY_SLOTS; j++)
                begin
                    if (prev_keys_reg[j] == b[2 + i])
                    begin
                        found = 1'b1;
                    end
                end
                job.codes[MAX_SLOTS + i] = b[2 + i];
                job.mask[MAX_SLOTS + i]  = (b[2 + i] != 8'd0) && !found;
                prev_keys_next[i]        = b[2 + i];
            end
        end
        else if (is_mouse)
        begin
            job.kind    = EV_MOUSE;
            job.mask[0] = 1'b1;
            job.mx      = b[2];
            job.my      = {b[4][3:0], b[3][7:4]};
            job.btn     = {4'd0, b[1]};
            job.wheel   = (report_length >= WHEEL_MIN_LEN) ? b[5] : 8'd0;
        end
        else if (is_pad)
        begin
            job.kind    = EV_PAD;
            job.mask[0] = 1'b1;
            if (layout == LAYOUT_DPAD)
            begin
                job.ph  = (b[3] < AXIS_LOW) ? DIR_NEG : (b[3] > AXIS_HIGH) ? DIR_POS : DIR_ZERO;
                job.pv  = (b[4] < AXIS_LOW) ? DIR_NEG : (b[4] > AXIS_HIGH) ? DIR_POS : DIR_ZERO;
                job.btn = {2'd0, b[6][5:0], b[5][7], b[5][4], b[5][6], b[5][5]};
            end
            else
            begin
                case (hat)
                    4'd1, 4'd2, 4'd3: job.ph = DIR_POS;
                    4'd5, 4'd6, 4'd7: job.ph = DIR_NEG;
                    default:          job.ph = DIR_ZERO;
                endcase
                case (hat)
                    4'd7, 4'd0, 4'd1: job.pv = DIR_NEG;
                    4'd3, 4'd4, 4'd5: job.pv = DIR_POS;
                    default:          job.pv = DIR_ZERO;
                endcase
                job.btn   = {b[6], b[5][4], b[5][7], b[5][5], b[5][6]};
                job.stick = {b[4] ^ STICK_BIAS, b[3] ^ STICK_BIAS,
                             b[2] ^ STICK_BIAS, b[1] ^ STICK_BIAS};
            end
        end
    end

    // a keyboard report with no change stores its keys but queues nothing
    assign push = accept && (job.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_keys_reg[i] <= 8'd0;
            end
        end
        else if (accept && is_key)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_keys_reg[i] <= prev_keys_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/hrd_queue.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module hrd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hrd_pkg::hrd_job_t      push_job,
    input  logic                   pop,
    output hrd_pkg::hrd_job_t      head_job,
    output hrd_pkg::hrd_q_status_t status
);
    import hrd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hrd_job_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/hrd_back.sv =====
// Back end: walk the head job and emit one event per cycle while out_stall is low.
`timescale 1ns / 1ps

module hrd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hrd_pkg::hrd_job_t      head_job,
    input  hrd_pkg::hrd_q_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             event_kind,
    output logic [7:0]             key_code,
    output logic [7:0]             key_modifiers,
    output logic                   key_down,
    output logic signed [7:0]      move_x,
    output logic signed [7:0]      move_y,
    output logic [11:0]            button_bits,
    output logic signed [7:0]      wheel_step,
    output logic signed [1:0]      pad_horizontal,
    output logic signed [1:0]      pad_vertical,
    output logic [31:0]            stick_values,
    output logic                   last_of_run
);
    import hrd_pkg::*;

    localparam int IDX_W = $clog2(EVENT_SLOTS);

    logic [EVENT_SLOTS-1:0] done_mask_reg, done_mask_next;
    logic [EVENT_SLOTS-1:0] rem;
    logic [EVENT_SLOTS-1:0] pick;
    logic [EVENT_SLOTS-1:0] rem_after;
    logic [IDX_W-1:0]       idx;
    logic                   head_valid;
    logic                   advance;
    logic                   is_key;
    logic                   out_valid_reg, out_valid_next;

    logic [1:0]  kind_reg;
    logic [7:0]  code_reg, mods_reg, mx_reg, my_reg, wheel_reg;
    logic        down_reg, last_reg;
    logic [11:0] btn_reg;
    logic [1:0]  ph_reg, pv_reg;
    logic [31:0] stick_reg;

    assign head_valid = !q_status.empty;
    assign rem        = head_job.mask & ~done_mask_reg;
    assign is_key     = (head_job.kind == EV_KEY);

    // lowest pending bit: releases come before presses
    always_comb
    begin
        idx = '0;
        for (int k = EVENT_SLOTS - 1; k >= 0; k--)
        begin
            if (rem[k])
                idx = IDX_W'(k);
        end
    end

    assign pick      = EVENT_SLOTS'(1) << idx;
    assign rem_after = rem & ~pick;
    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = advance && (rem_after == '0);

    always_comb
    begin
        done_mask_next = done_mask_reg;
        if (advance)
            done_mask_next = (rem_after == '0) ? '0 : (done_mask_reg | pick);
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_mask_reg <= done_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg  <= head_job.kind;
            code_reg  <= is_key ? head_job.codes[idx] : 8'd0;
            mods_reg  <= head_job.mods;
            down_reg  <= is_key && (idx >= IDX_W'(MAX_SLOTS));
            mx_reg    <= head_job.mx;
            my_reg    <= head_job.my;
            btn_reg   <= head_job.btn;
            wheel_reg <= head_job.wheel;
            ph_reg    <= head_job.ph;
            pv_reg    <= head_job.pv;
            stick_reg <= head_job.stick;
            last_reg  <= (rem_after == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign key_code       = code_reg;
    assign key_modifiers  = mods_reg;
    assign key_down       = down_reg;
    assign move_x         = mx_reg;
    assign move_y         = my_reg;
    assign button_bits    = btn_reg;
    assign wheel_step     = wheel_reg;
    assign pad_horizontal = ph_reg;
    assign pad_vertical   = pv_reg;
    assign stick_values   = stick_reg;
    assign last_of_run    = last_reg;

    a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (rem != '0))
        else $error("queued job has no pending event");
    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((done_mask_reg & ~head_job.mask) == '0))
        else $error("emitted mask outside head job");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (done_mask_reg == '0))
        else $error("stale emitted mask with empty queue");

endmodule

// ===== hw/rtl/hid_report_event_decoder_core.sv =====
// Top level of the HID report event decoder: front end, job queue, back end.
// Path: the first event of a report goes through a job queue entry, then the output register.
// Throughput: a report is taken every cycle while the two-entry job queue has room;
//   the back end emits one event per cycle while out_stall is low, and a keyboard
//   job yields one to twelve events (releases plus presses), mouse or gamepad one.
// Reset: asynchronous, clears held keys, gamepad layout (to none) and the queue.
`timescale 1ns / 1ps

module hid_report_event_decoder_core #(
    parameter int KEY_SLOTS = hrd_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // report input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         device_kind,
    input  logic [4:0]         report_length,
    input  logic [31:0]        report_bytes_low,
    input  logic [31:0]        report_bytes_high,
    // event output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_kind,
    output logic [7:0]         key_code,
    output logic [7:0]         key_modifiers,
    output logic               key_down,
    output logic signed [7:0]  move_x,
    output logic signed [7:0]  move_y,
    output logic [11:0]        button_bits,
    output logic signed [7:0]  wheel_step,
    output logic signed [1:0]  pad_horizontal,
    output logic signed [1:0]  pad_vertical,
    output logic [31:0]        stick_values,
    output logic               last_of_run,
    // gamepad layout register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);
    import hrd_pkg::*;

    logic [1:0]    gamepad_layout_reg;
    logic          push;
    logic          pop;
    hrd_job_t      push_job;
    hrd_job_t      head_job;
    hrd_q_status_t q_status;

    // The register is always writable; writes must come only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamepad_layout_reg <= 2'd0;
        end
        else if (cfg_valid)
        begin
            gamepad_layout_reg <= cfg_data;
        end
    end

    // Front end: classify the report, diff key codes against the held set,
    // store the new keys and queue a job when it yields any event.
    hrd_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .device_kind       (device_kind),
        .report_length     (report_length),
        .report_bytes_low  (report_bytes_low),
        .report_bytes_high (report_bytes_high),
        .layout            (gamepad_layout_reg),
        .q_status          (q_status),
        .push              (push),
        .job               (push_job)
    );

    // Queue: decouple report intake from event emission.
    hrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back end: emit the head job's events in order into the output register, which advances
    // while a job is queued and the output register is empty or the consumer is not stalling.
    hrd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .q_status       (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .key_code       (key_code),
        .key_modifiers  (key_modifiers),
        .key_down       (key_down),
        .move_x         (move_x),
        .move_y         (move_y),
        .button_bits    (button_bits),
        .wheel_step     (wheel_step),
        .pad_horizontal (pad_horizontal),
        .pad_vertical   (pad_vertical),
        .stick_values   (stick_values),
        .last_of_run    (last_of_run)
    );

endmodule
